// ===== sv/rtt_pkg.sv =====
// Shared constants and field widths for the raster-to-tile reorder block.
package rtt_pkg;

  localparam int unsigned TILE_ROWS = 8;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned COL_W     = 6;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_W     = 7;

  // Output tdata: tile_word, tile_column, row_in_tile, then zero pad to whole bytes
  localparam int unsigned OUT_BITS     = WORD_W + COL_W + ROW_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] TILES_WIDE_RST = 7'd1;

  typedef enum logic {
    MODE_DATA  = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_t;

endpackage

// ===== sv/raster_to_tile_reorder_core.sv =====
// Raster-to-tile reorder: ping-pong strip store and tile-order read-out.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tdata: pixel_word; s_tuser: mode
//  m_*      out  m_tvalid / m_tready    m_tdata: tile_word, tile_column, row_in_tile;
//                                       m_tlast: strip_end
//  cfg_*    in   cfg_valid / cfg_ready  cfg_data: tiles_wide
//
// One item is taken per clock while the output is not stalled. Each accepted item does
// at most one store write (none for a flush) and at most one store read; the read data
// register is the result register, so a result appears in the cycle after its item is
// accepted. The store has one write and one read port. Reset clears the positions, the
// bank select and the pending flag and returns the width to one; the store itself is
// not cleared. s_tready falls only while a result waits and m_tready is low.
module raster_to_tile_reorder_core #(
  parameter int unsigned MAX_TILES_WIDE = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: pixel_word[31:0]
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rtt_pkg::WORD_W-1:0]         s_tdata,
  // s_tuser: mode[0]
  input  logic                               s_tuser,
  // m_tdata: tile_word[31:0], tile_column[37:32], row_in_tile[40:38], zeros above
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rtt_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rtt_pkg::CFG_W-1:0]          cfg_data
);

  localparam int unsigned BANK_WORDS  = rtt_pkg::TILE_ROWS * MAX_TILES_WIDE;
  localparam int unsigned STORE_WORDS = 2 * BANK_WORDS;
  localparam int unsigned POS_W       = $clog2(BANK_WORDS);
  localparam int unsigned ADDR_W      = POS_W + 1;
  localparam int unsigned TW_W        = $clog2(MAX_TILES_WIDE + 1);
  localparam int unsigned PAD_W       = rtt_pkg::OUT_TDATA_W - rtt_pkg::OUT_BITS;

  logic [rtt_pkg::CFG_W-1:0]   tiles_wide;
  logic [POS_W-1:0]            write_position, write_position_next;
  logic [POS_W-1:0]            read_position, read_position_next;
  logic                        write_bank, write_bank_next;
  logic                        strip_pending, strip_pending_next;

  logic [rtt_pkg::WORD_W-1:0]  strip_store [STORE_WORDS];

  logic                        out_valid;
  logic [rtt_pkg::WORD_W-1:0]  out_word;
  logic [rtt_pkg::COL_W-1:0]   out_column, column_next;
  logic [rtt_pkg::ROW_W-1:0]   out_row, row_next;
  logic                        out_last, last_next;

  logic                        accept;
  logic                        is_flush;
  logic [TW_W-1:0]             tw;
  int unsigned                 total;
  int unsigned                 tile;
  int unsigned                 bank_addr;
  logic                        emit;
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr, rd_addr;

  assign cfg_ready = 1'b1;
  assign s_tready  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign is_flush  = (rtt_pkg::mode_t'(s_tuser) == rtt_pkg::MODE_FLUSH);

  // Clamp the width: zero acts as one, anything above the maximum as the maximum
  always_comb begin
    priority if (tiles_wide == '0) begin
      tw = TW_W'(1);
    end else if (32'(tiles_wide) > 32'(MAX_TILES_WIDE)) begin
      tw = TW_W'(MAX_TILES_WIDE);
    end else begin
      tw = TW_W'(tiles_wide);
    end
  end

  always_comb begin
    total     = 32'(tw) * rtt_pkg::TILE_ROWS;
    tile      = 32'(read_position) >> rtt_pkg::ROW_W;
    row_next  = read_position[rtt_pkg::ROW_W-1:0];
    column_next = rtt_pkg::COL_W'(tile);
    bank_addr = 32'(row_next) * 32'(tw) + tile;
    rd_addr   = {~write_bank, POS_W'(bank_addr)};
    wr_addr   = {write_bank, write_position};
    last_next = (32'(read_position) + 1 == total);

    emit                = 1'b0;
    strip_pending_next  = strip_pending;
    read_position_next  = read_position;
    write_position_next = write_position;
    write_bank_next     = write_bank;

    if (strip_pending) begin
      if (32'(read_position) >= total) begin
        // width shrank past the read point: retire the strip silently
        strip_pending_next = 1'b0;
        read_position_next = '0;
      end else begin
        emit = 1'b1;
        if (last_next) begin
          strip_pending_next = 1'b0;
          read_position_next = '0;
        end else begin
          read_position_next = read_position + 1'b1;
        end
      end
    end

    if (is_flush) begin
      // drop the partial strip
      write_position_next = '0;
    end else if (32'(write_position) + 1 >= total) begin
      write_bank_next     = ~write_bank;
      write_position_next = '0;
      strip_pending_next  = 1'b1;
      read_position_next  = '0;
    end else begin
      write_position_next = write_position + 1'b1;
    end
  end

  assign wr_en = accept && !is_flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_wide     <= rtt_pkg::TILES_WIDE_RST;
      write_position <= '0;
      read_position  <= '0;
      write_bank     <= 1'b0;
      strip_pending  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tiles_wide <= cfg_data;
      end
      if (accept) begin
        write_position <= write_position_next;
        read_position  <= read_position_next;
        write_bank     <= write_bank_next;
        strip_pending  <= strip_pending_next;
        out_valid      <= emit;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Store write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      strip_store[wr_addr] <= s_tdata;
    end
  end

  // Store read port; its data register is the result register, held while stalled
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_word   <= strip_store[rd_addr];
      out_column <= column_next;
      out_row    <= row_next;
      out_last   <= last_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_row, out_column, out_word};
  assign m_tlast  = out_last;

endmodule
